// ----- hdl/pllm_pkg.sv -----
// shared types and constants for the page linked list manager
package pllm_pkg;

    localparam int PAGE_W = 10;
    localparam int PAGE_COUNT_DEF = 1024;

    typedef logic [PAGE_W-1:0] page_t;

    localparam page_t NULL_PAGE = '0;

    typedef enum logic [1:0] {
        OP_PUSH_HEAD = 2'd0,
        OP_PUSH_TAIL = 2'd1,
        OP_POP_HEAD  = 2'd2,
        OP_UNLINK    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_MISMATCH = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef struct packed {
        op_t   operation;
        page_t page_num;
        page_t prev_page;
    } req_t;

    typedef struct packed {
        page_t   removed_page;
        status_t status;
        page_t   head_page;
        page_t   tail_page;
        page_t   node_count;
    } rsp_t;

    typedef struct packed {
        op_t   operation;
        page_t page_num;
        page_t prev_page;
        logic  page_bad;
        logic  prev_bad;
    } cmd_t;

endpackage

// ----- hdl/pllm_ram.sv -----
// generic single-port ram with registered read
module pllm_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

// ----- hdl/pllm_front.sv -----
// request intake: page range checks and a two-entry command queue
module pllm_front #(
    parameter int PAGE_COUNT = pllm_pkg::PAGE_COUNT_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  pllm_pkg::req_t req,
    output logic           cmd_valid,
    input  logic           cmd_take,
    output pllm_pkg::cmd_t cmd
);

    import pllm_pkg::*;

    cmd_t        q_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  fill_reg;
    logic        push;
    logic        pop;
    cmd_t        cls;

    always_comb
    begin
        cls.operation = req.operation;
        cls.page_num  = req.page_num;
        cls.prev_page = req.prev_page;
        cls.page_bad  = (req.page_num == NULL_PAGE) || (32'(req.page_num) >= PAGE_COUNT);
        cls.prev_bad  = (32'(req.prev_page) >= PAGE_COUNT);
    end

    assign req_stall = (fill_reg == 2'd2);
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = req_valid && !req_stall;
    assign pop       = cmd_take && cmd_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

// ----- hdl/pllm_back.sv -----
// list sequencer: head, tail, count and link memory accesses
module pllm_back #(
    parameter int PAGE_COUNT = pllm_pkg::PAGE_COUNT_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_take,
    input  pllm_pkg::cmd_t cmd,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output pllm_pkg::rsp_t rsp
);

    import pllm_pkg::*;

    localparam int AW       = $clog2(PAGE_COUNT);
    localparam int PAGE_MAX = (1 << PAGE_W) - 1;
    localparam int LIST_CAP = (PAGE_COUNT - 1 < PAGE_MAX) ? PAGE_COUNT - 1 : PAGE_MAX;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP_RD,
        S_UL_RD,
        S_WR2
    } state_t;

    state_t  state_reg, state_next;
    page_t   head_reg, head_next;
    page_t   tail_reg, tail_next;
    page_t   count_reg, count_next;
    page_t   page_reg, page_next;
    page_t   prev_reg, prev_next;
    page_t   removed_reg, removed_next;
    page_t   wr_addr_reg, wr_addr_next;
    page_t   wr_data_reg, wr_data_next;
    logic    rsp_valid_reg, rsp_valid_next;
    rsp_t    rsp_reg, rsp_next;

    logic    ram_en;
    logic    ram_we;
    page_t   ram_page;
    page_t   ram_wdata;
    page_t   ram_rdata;
    logic    done;
    page_t   rm;
    status_t st;
    logic    rsp_free;
    page_t   count_dec;

    pllm_ram #(
        .WIDTH (PAGE_W),
        .DEPTH (PAGE_COUNT)
    ) u_link_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (AW'(ram_page)),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign count_dec = (count_reg != '0) ? count_reg - 1'b1 : '0;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        page_next      = page_reg;
        prev_next      = prev_reg;
        removed_next   = removed_reg;
        wr_addr_next   = wr_addr_reg;
        wr_data_next   = wr_data_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        ram_en         = 1'b0;
        ram_we         = 1'b0;
        ram_page       = cmd.page_num;
        ram_wdata      = NULL_PAGE;
        cmd_take       = 1'b0;
        done           = 1'b0;
        rm             = NULL_PAGE;
        st             = ST_OK;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && rsp_free)
                begin
                    cmd_take  = 1'b1;
                    page_next = cmd.page_num;
                    prev_next = cmd.prev_page;
                    case (cmd.operation)
                        OP_PUSH_HEAD, OP_PUSH_TAIL:
                        begin
                            if (cmd.page_bad ||
                                (cmd.operation == OP_PUSH_HEAD && cmd.page_num == head_reg))
                            begin
                                done = 1'b1;
                                st   = ST_MISMATCH;
                            end
                            else if (count_reg >= PAGE_W'(LIST_CAP))
                            begin
                                done = 1'b1;
                                st   = ST_FULL;
                            end
                            else if (cmd.operation == OP_PUSH_HEAD)
                            begin
                                ram_en     = 1'b1;
                                ram_we     = 1'b1;
                                ram_wdata  = head_reg;
                                head_next  = cmd.page_num;
                                count_next = count_reg + 1'b1;
                                if (head_reg == NULL_PAGE)
                                begin
                                    tail_next = cmd.page_num;
                                end
                                done = 1'b1;
                            end
                            else
                            begin
                                ram_en     = 1'b1;
                                ram_we     = 1'b1;
                                ram_wdata  = NULL_PAGE;
                                tail_next  = cmd.page_num;
                                count_next = count_reg + 1'b1;
                                if (tail_reg == NULL_PAGE)
                                begin
                                    head_next = cmd.page_num;
                                    done      = 1'b1;
                                end
                                else
                                begin
                                    wr_addr_next = tail_reg;
                                    wr_data_next = cmd.page_num;
                                    removed_next = NULL_PAGE;
                                    state_next   = S_WR2;
                                end
                            end
                        end
                        OP_POP_HEAD:
                        begin
                            if (head_reg == NULL_PAGE)
                            begin
                                done = 1'b1;
                                st   = ST_EMPTY;
                            end
                            else if (head_reg == tail_reg)
                            begin
                                ram_en     = 1'b1;
                                ram_we     = 1'b1;
                                ram_page   = head_reg;
                                rm         = head_reg;
                                head_next  = NULL_PAGE;
                                tail_next  = NULL_PAGE;
                                count_next = count_dec;
                                done       = 1'b1;
                            end
                            else
                            begin
                                ram_en       = 1'b1;
                                ram_page     = head_reg;
                                removed_next = head_reg;
                                state_next   = S_POP_RD;
                            end
                        end
                        OP_UNLINK:
                        begin
                            if (cmd.page_bad || cmd.prev_bad)
                            begin
                                done = 1'b1;
                                st   = ST_MISMATCH;
                            end
                            else if (head_reg == NULL_PAGE)
                            begin
                                done = 1'b1;
                                st   = ST_EMPTY;
                            end
                            else if (cmd.prev_page == NULL_PAGE && cmd.page_num != head_reg)
                            begin
                                done = 1'b1;
                                st   = ST_MISMATCH;
                            end
                            else
                            begin
                                ram_en     = 1'b1;
                                state_next = S_UL_RD;
                            end
                        end
                        default:
                        begin
                            done = 1'b1;
                            st   = ST_MISMATCH;
                        end
                    endcase
                end
            end
            S_POP_RD:
            begin
                ram_en     = 1'b1;
                ram_we     = 1'b1;
                ram_page   = removed_reg;
                head_next  = ram_rdata;
                count_next = count_dec;
                rm         = removed_reg;
                done       = 1'b1;
                state_next = S_IDLE;
            end
            S_UL_RD:
            begin
                count_next = count_dec;
                if (tail_reg == page_reg)
                begin
                    tail_next = prev_reg;
                end
                ram_en = 1'b1;
                ram_we = 1'b1;
                if (prev_reg == NULL_PAGE)
                begin
                    head_next  = ram_rdata;
                    ram_page   = page_reg;
                    rm         = page_reg;
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    ram_page     = prev_reg;
                    ram_wdata    = ram_rdata;
                    wr_addr_next = page_reg;
                    wr_data_next = NULL_PAGE;
                    removed_next = page_reg;
                    state_next   = S_WR2;
                end
            end
            S_WR2:
            begin
                ram_en     = 1'b1;
                ram_we     = 1'b1;
                ram_page   = wr_addr_reg;
                ram_wdata  = wr_data_reg;
                rm         = removed_reg;
                done       = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        rsp_next = rsp_reg;
        if (done)
        begin
            rsp_valid_next        = 1'b1;
            rsp_next.removed_page = rm;
            rsp_next.status       = st;
            rsp_next.head_page    = head_next;
            rsp_next.tail_page    = tail_next;
            rsp_next.node_count   = count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= NULL_PAGE;
            tail_reg      <= NULL_PAGE;
            count_reg     <= '0;
            page_reg      <= NULL_PAGE;
            prev_reg      <= NULL_PAGE;
            removed_reg   <= NULL_PAGE;
            wr_addr_reg   <= NULL_PAGE;
            wr_data_reg   <= NULL_PAGE;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            page_reg      <= page_next;
            prev_reg      <= prev_next;
            removed_reg   <= removed_next;
            wr_addr_reg   <= wr_addr_next;
            wr_data_reg   <= wr_data_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

endmodule

// ----- hdl/page_linked_list_manager.sv -----
// top level of the page linked list manager
// Keeps one singly linked list of pages in a single-port link memory of PAGE_COUNT
// entries plus head, tail and count registers; page 0 is the null link. Each request
// gives exactly one response. Requests pass through a two-entry command queue into the
// list sequencer, doing at most one link memory access per cycle. Rejected requests,
// head pushes, pushes to an empty list and pops of the only page end in the idle state;
// a pop reads, then clears the head's link; other tail pushes write the new link, then
// the old tail's; an unlink copies the page's link to the predecessor's link or the
// head and clears it. A request enters the sequencer only when the response register is
// free or being taken in the same cycle. The link memory needs no clearing after reset.
module page_linked_list_manager #(
    parameter int PAGE_COUNT = pllm_pkg::PAGE_COUNT_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  pllm_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output pllm_pkg::rsp_t rsp
);

    import pllm_pkg::*;

    cmd_t cmd;
    logic cmd_valid;
    logic cmd_take;

    pllm_front #(
        .PAGE_COUNT (PAGE_COUNT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd       (cmd)
    );

    pllm_back #(
        .PAGE_COUNT (PAGE_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule
